// ----- sv/rilbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rilbp_pkg
// Shared constants, types and the rotation-minimum function for the
// rotation-invariant 3x3 LBP block.
// ----------------------------------------------------------------------------
package rilbp_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int HEIGHT_LIMIT      = 4096;
    localparam int ROW_W             = 12;   // row counter, 0..HEIGHT_LIMIT-1
    localparam int PIX_W             = 8;
    localparam int CFG_W             = 13;   // widest config register
    localparam int WIDTH_REG_W       = 11;
    localparam int HEIGHT_REG_W      = 13;

    // config register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [PIX_W-1:0] code;
        logic             last;
    } result_t;

    // smallest of the eight circular rotations of an 8-bit code
    function automatic logic [7:0] rot_min(input logic [7:0] code);
        logic [7:0] best;
        logic [7:0] v;
        best = code;
        v    = code;
        for (int k = 0; k < 7; k++) begin
            v = {v[0], v[7:1]};
            if (v < best) begin
                best = v;
            end
        end
        return best;
    endfunction

endpackage
`default_nettype wire

// ----- sv/rotation_invariant_lbp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_invariant_lbp
// Streaming rotation-invariant 3x3 local binary pattern over a grey frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pixel): one 8-bit grey pixel per
//   word, raster order. Output channel (out_valid / out_stall /
//   pattern_code / frame_last): one word per interior pixel; border pixels
//   give none. frame_last marks the final code of the frame.
//   Config: cfg_we with cfg_index 0 sets image_width, 1 sets image_height;
//   any write restarts the frame. Write only while the block is idle.
// Timing:
//   One pixel per clock sustained while the output is not stalled. A pixel
//   accepted passes through the line-store read, the compare stage
//   register, then rotation minimum and queue write; its code then shows
//   on the output from the queue head.
// Reset:
//   Counters, window and queue clear; width 20, height 40. Line stores are
//   not cleared: every entry a result uses is written earlier in the frame.
// Stall:
//   A 4-word result queue absorbs output stalls; in_stall rises when queue
//   plus in-flight words could fill it, so no word is lost.
// ----------------------------------------------------------------------------
module rotation_invariant_lbp #(
    parameter int MAX_WIDTH = rilbp_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // pixel input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [rilbp_pkg::PIX_W-1:0]    pixel,
    // code output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [rilbp_pkg::PIX_W-1:0]    pattern_code,
    output logic                                frame_last,
    // config write port
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [rilbp_pkg::CFG_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = rilbp_pkg::ROW_W;
    localparam int PW = rilbp_pkg::PIX_W;

    // ---------------------------------------------------------------- config
    logic [rilbp_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [rilbp_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [CW-1:0]                      last_col;
    logic [RW-1:0]                      last_row;

    // clamp the registers to the usable range
    always_comb
    begin
        if (width_reg < 11'd3)
        begin
            last_col = CW'(2);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CW'(width_reg - 11'd1);
        end

        if (height_reg < 13'd3)
        begin
            last_row = RW'(2);
        end
        else if (32'(height_reg) > rilbp_pkg::HEIGHT_LIMIT)
        begin
            last_row = RW'(rilbp_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            last_row = RW'(height_reg - 13'd1);
        end
    end

    // ------------------------------------------------------------- counters
    logic          in_accept;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    assign in_accept = in_valid && !in_stall;

    // config write wins over an accept in the same cycle
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd20;
            height_reg <= 13'd40;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rilbp_pkg::CFG_IDX_WIDTH:
                        width_reg  <= cfg_data[rilbp_pkg::WIDTH_REG_W-1:0];
                    rilbp_pkg::CFG_IDX_HEIGHT:
                        height_reg <= cfg_data[rilbp_pkg::HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------- stage 1: read
    // line-store read issued at accept; data lands with the stage-1 word
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic [PW-1:0] s1_pix_reg;
    logic [PW-1:0] top;
    logic [PW-1:0] mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_emit_reg <= (row_reg >= RW'(2)) && (col_reg >= CW'(2));
            s1_last_reg <= (row_reg == last_row) && (col_reg == last_col);
            s1_col_reg  <= col_reg;
            s1_pix_reg  <= pixel;
        end
    end

    // read-modify-write: upper takes the old middle, middle the new pixel.
    // The write lands in the cycle after its read; the next read is always a
    // different column (width >= 3), so no forwarding path is needed.
    rilbp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (in_accept),
        .rd_addr   (col_reg),
        .rd_upper  (top),
        .rd_middle (mid),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_col_reg),
        .wr_upper  (mid),
        .wr_middle (s1_pix_reg)
    );

    // ------------------------------------------------ stage 1: window, code
    // win_reg[row*2 + c]: row 0 top, c 0 older column
    logic [PW-1:0] win_reg [6];
    logic [7:0]    raw_code;
    logic [PW-1:0] ctr;

    always_comb
    begin
        ctr      = win_reg[3];
        raw_code = {win_reg[0] >= ctr, win_reg[1] >= ctr, top >= ctr,
                    mid >= ctr, s1_pix_reg >= ctr, win_reg[5] >= ctr,
                    win_reg[4] >= ctr, win_reg[2] >= ctr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------ stage 2: rotation min
    logic       s2_valid_reg;
    logic [7:0] s2_code_reg;
    logic       s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_code_reg <= raw_code;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ----------------------------------------------------------- out queue
    rilbp_pkg::result_t             push_data;
    rilbp_pkg::result_t             head;
    logic [rilbp_pkg::FIFO_CW-1:0]  fifo_count;
    logic [rilbp_pkg::FIFO_CW-1:0]  inflight;
    logic                           out_pop;

    assign push_data.code = rilbp_pkg::rot_min(s2_code_reg);
    assign push_data.last = s2_last_reg;
    assign out_pop        = out_valid && !out_stall;

    rilbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .pop       (out_pop),
        .head      (head),
        .count     (fifo_count)
    );

    // reserve a slot for every word still in the pipe
    assign inflight = fifo_count + rilbp_pkg::FIFO_CW'(s1_valid_reg)
                    + rilbp_pkg::FIFO_CW'(s2_valid_reg);
    assign in_stall = (inflight >= rilbp_pkg::FIFO_CW'(rilbp_pkg::FIFO_DEPTH));

    assign out_valid    = (fifo_count != '0);
    assign pattern_code = head.code;
    assign frame_last   = head.last;

`ifndef SYNTHESIS
    // write-back and a fresh read never hit the same column
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && in_accept) |-> (s1_col_reg != col_reg))
        else $error("line store read and write hit the same column");

    // queue never overflows
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((fifo_count < rilbp_pkg::FIFO_CW'(rilbp_pkg::FIFO_DEPTH))
                          || out_pop))
        else $error("result queue overflow");

    // a config write restarts the frame
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (col_reg == '0) && (row_reg == '0))
        else $error("config write did not restart the frame");
`endif

endmodule
`default_nettype wire

// ----- sv/rilbp_line_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rilbp_line_store
// Two single-port-write, registered-read line memories (upper and middle).
// ----------------------------------------------------------------------------
module rilbp_line_store #(
    parameter int DEPTH = rilbp_pkg::MAX_WIDTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [rilbp_pkg::PIX_W-1:0] rd_upper,
    output logic      [rilbp_pkg::PIX_W-1:0] rd_middle,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [rilbp_pkg::PIX_W-1:0] wr_upper,
    input  wire logic [rilbp_pkg::PIX_W-1:0] wr_middle
);

    logic [rilbp_pkg::PIX_W-1:0] upper_mem  [DEPTH];
    logic [rilbp_pkg::PIX_W-1:0] middle_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            rd_upper  <= upper_mem[rd_addr];
            rd_middle <= middle_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rilbp_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rilbp_out_fifo
// Small result queue that decouples the fixed pipeline from output stalls.
// ----------------------------------------------------------------------------
module rilbp_out_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire rilbp_pkg::result_t                push_data,
    input  wire logic                              pop,
    output rilbp_pkg::result_t                     head,
    output logic [rilbp_pkg::FIFO_CW-1:0]          count
);

    rilbp_pkg::result_t                entry_reg [rilbp_pkg::FIFO_DEPTH];
    logic [rilbp_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rilbp_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rilbp_pkg::FIFO_CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire
